// File: hdl/ept_pkg.sv
// Shared widths, constants, register indexes and control structs of the tachometer.
package ept_pkg;

  localparam int TIME_BITS = 32;
  localparam int SUM_W     = 32;
  localparam int CNT_W     = 8;
  localparam int MIN_W     = 20;
  localparam int MAXR_W    = 10;
  localparam int CPR_W     = 16;
  localparam int WGT_W     = 17;
  localparam int RPM_W     = 18;
  localparam int SMOOTH_FRAC_BITS = 16;
  localparam int ACC_W     = 10 + SMOOTH_FRAC_BITS;
  localparam int WGT_FRAC  = 16;
  localparam int DEN_W     = SUM_W + CPR_W;
  localparam int NUM_W     = 42;
  localparam int PLAUS_W   = MAXR_W + DEN_W;
  localparam int PROD_W    = WGT_W + ACC_W;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INSTANT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_REV   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_WGT   = 2'd3;

  localparam logic [MIN_W-1:0]  MIN_INTERVAL_RST = 20'd1700;
  localparam logic [MAXR_W-1:0] MAX_INSTANT_RST  = 10'd145;
  localparam logic [CPR_W-1:0]  COUNTS_REV_RST   = 16'd240;
  localparam logic [WGT_W-1:0]  SMOOTH_WGT_RST   = 17'd3277;

  localparam logic [WGT_W-1:0]    WGT_ONE     = 17'd65536;
  localparam logic [NUM_W-1:0]    RPM_Q8_NUM  = 42'd15360000000;
  localparam logic [PLAUS_W-1:0]  US_PER_MIN  = 58'd60000000;
  localparam logic [RPM_W-1:0]    RPM_Q8_MAX  = 18'd262143;
  localparam logic [CNT_W-1:0]    CNT_FULL    = 8'd255;
  localparam logic [PROD_W:0]     ROUND_HALF  = 44'd32768;

  typedef struct packed {
    logic load;       // capture input beat
    logic diff;       // form edge interval
    logic meas;       // qualify interval, update window, form denominator
    logic w_prep;     // form window numerator and denominator, clear window
    logic w_sat;      // saturate window rpm
    logic div_start;  // launch divider
    logic div_store;  // take quotient
    logic sm_mul;     // smoothing products
    logic sm_add;     // smoothing sum
    logic out_load;   // load output register
  } ept_cmd_t;

  typedef struct packed {
    logic is_win;
    logic meas_ok;
    logic plaus;
    logic cnt_zero;
    logic den_zero;
    logic div_done;
  } ept_sts_t;

  function automatic logic [RPM_W-1:0] sat_rpm(input logic [NUM_W-1:0] q);
    if (q[NUM_W-1:RPM_W] != '0) begin
      return RPM_Q8_MAX;
    end
    return q[RPM_W-1:0];
  endfunction

endpackage

// File: hdl/ept_divider.sv
// Restoring divider, one quotient bit per cycle.
module ept_divider import ept_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic [NUM_W-1:0] quotient,
  output logic             done
);

  localparam int STEP_W = $clog2(NUM_W + 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DEN_W-1:0]  rem_r;
  logic [NUM_W-1:0]  quo_r;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff_val;
  logic              take;

  assign trial    = {rem_r, quo_r[NUM_W-1]};
  assign diff_val = trial - {1'b0, divisor};
  assign take     = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 1'b1;
      end else if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      rem_r <= take ? diff_val[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], take};
    end else if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// File: hdl/ept_datapath.sv
// Datapath: configuration, window state, multipliers, divider and output register.
module ept_datapath import ept_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  ept_cmd_t              cmd,
  output ept_sts_t              sts,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  logic [MIN_W-1:0]     min_r;
  logic [MAXR_W-1:0]    maxr_r;
  logic [CPR_W-1:0]     cpr_r;
  logic [WGT_W-1:0]     wgt_r;

  logic [TIME_BITS-1:0] last_r;
  logic [SUM_W-1:0]     sum_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [RPM_W-1:0]     inst_r;
  logic [ACC_W-1:0]     acc_r;

  logic [TIME_BITS-1:0] ts_r;
  logic                 kind_r;
  logic [TIME_BITS-1:0] iv_r;
  logic                 lt_r;
  logic                 meas_r;
  logic [DEN_W-1:0]     den_r;
  logic [NUM_W-1:0]     num_r;
  logic [RPM_W-1:0]     win_r;
  logic                 valid_r;
  logic [PROD_W-1:0]    proda_r;
  logic [PROD_W-1:0]    prodb_r;

  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_kind_r;

  logic                 meas_nxt;
  logic [SUM_W:0]       sum_nxt;
  logic [PLAUS_W-1:0]   plaus_prod;
  logic [WGT_W-1:0]     wgt_eff;
  logic [WGT_W-1:0]     wgt_inv;
  logic [ACC_W-1:0]     rpm_frac;
  logic [PROD_W:0]      acc_sum;
  logic [ACC_W-1:0]     acc_nxt;
  logic [NUM_W-1:0]     quotient;
  logic                 div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= MIN_INTERVAL_RST;
      maxr_r <= MAX_INSTANT_RST;
      cpr_r  <= COUNTS_REV_RST;
      wgt_r  <= SMOOTH_WGT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_INTERVAL: min_r  <= cfg_wdata[MIN_W-1:0];
        CFG_MAX_INSTANT:  maxr_r <= cfg_wdata[MAXR_W-1:0];
        CFG_COUNTS_REV:   cpr_r  <= cfg_wdata[CPR_W-1:0];
        CFG_SMOOTH_WGT:   wgt_r  <= WGT_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign meas_nxt   = lt_r && (iv_r > TIME_BITS'(min_r));
  assign sum_nxt    = {1'b0, sum_r} + (SUM_W + 1)'(iv_r);
  assign plaus_prod = PLAUS_W'(maxr_r) * PLAUS_W'(den_r);
  assign wgt_eff    = (wgt_r > WGT_ONE) ? WGT_ONE : wgt_r;
  assign wgt_inv    = WGT_ONE - wgt_eff;
  assign rpm_frac   = {win_r, (SMOOTH_FRAC_BITS - 8)'(0)};
  assign acc_sum    = {1'b0, proda_r} + {1'b0, prodb_r} + ROUND_HALF;
  assign acc_nxt    = acc_sum[WGT_FRAC +: ACC_W];

  // Window and speed state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
      inst_r <= '0;
      acc_r  <= '0;
    end else begin
      if (cmd.diff) begin
        last_r <= ts_r;
      end
      if (cmd.meas && meas_nxt && (cnt_r != CNT_FULL) && !sum_nxt[SUM_W]) begin
        cnt_r <= cnt_r + 1'b1;
        sum_r <= sum_nxt[SUM_W-1:0];
      end
      if (cmd.w_prep) begin
        cnt_r <= '0;
        sum_r <= '0;
      end
      if (cmd.div_store && !kind_r) begin
        inst_r <= sat_rpm(quotient);
      end
      if (cmd.sm_add) begin
        acc_r <= acc_nxt;
      end
    end
  end

  // Per-item working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ts_r    <= in_tdata[TIME_BITS-1:0];
      kind_r  <= in_tuser;
      win_r   <= '0;
      valid_r <= 1'b0;
    end
    if (cmd.diff) begin
      iv_r  <= ts_r - last_r;
      lt_r  <= (last_r < ts_r);
      num_r <= RPM_Q8_NUM;
    end
    if (cmd.meas) begin
      meas_r <= meas_nxt;
      den_r  <= DEN_W'(iv_r) * DEN_W'(cpr_r);
    end
    if (cmd.w_prep) begin
      den_r   <= DEN_W'(sum_r) * DEN_W'(cpr_r);
      num_r   <= RPM_Q8_NUM * NUM_W'(cnt_r);
      valid_r <= (cnt_r != '0);
    end
    if (cmd.w_sat) begin
      win_r <= RPM_Q8_MAX;
    end
    if (cmd.div_store && kind_r) begin
      win_r <= sat_rpm(quotient);
    end
    if (cmd.sm_mul) begin
      proda_r <= PROD_W'(wgt_inv) * PROD_W'(acc_r);
      prodb_r <= PROD_W'(wgt_eff) * PROD_W'(rpm_frac);
    end
    if (cmd.out_load) begin
      out_kind_r <= kind_r;
      out_data_r <= {1'b0, acc_r[SMOOTH_FRAC_BITS +: 10], valid_r, win_r, inst_r};
    end
  end

  ept_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (num_r),
    .divisor  (den_r),
    .quotient (quotient),
    .done     (div_done)
  );

  assign sts.is_win   = kind_r;
  assign sts.meas_ok  = meas_r;
  assign sts.plaus    = (plaus_prod > US_PER_MIN);
  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.den_zero = (den_r == '0);
  assign sts.div_done = div_done;

  assign out_tdata = out_data_r;
  assign out_tuser = out_kind_r;

endmodule

// File: hdl/ept_ctrl.sv
// Controller: sequences one beat at a time through the datapath.
module ept_ctrl import ept_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  ept_sts_t sts,
  output ept_cmd_t cmd
);

  typedef enum logic [3:0] {
    IDLE,
    E_DIFF,
    E_MEAS,
    E_TEST,
    W_PREP,
    W_CHECK,
    DIV_WAIT,
    SM_MUL,
    SM_ADD,
    FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = E_DIFF;
        end
      end
      E_DIFF: begin
        // window ends skip the edge steps
        if (sts.is_win) begin
          state_nxt = W_PREP;
        end else begin
          cmd.diff  = 1'b1;
          state_nxt = E_MEAS;
        end
      end
      E_MEAS: begin
        cmd.meas  = 1'b1;
        state_nxt = E_TEST;
      end
      E_TEST: begin
        if (sts.meas_ok && sts.plaus) begin
          cmd.div_start = 1'b1;
          state_nxt     = DIV_WAIT;
        end else begin
          state_nxt = FINISH;
        end
      end
      W_PREP: begin
        cmd.w_prep = 1'b1;
        state_nxt  = sts.cnt_zero ? FINISH : W_CHECK;
      end
      W_CHECK: begin
        if (sts.den_zero) begin
          cmd.w_sat = 1'b1;
          state_nxt = SM_MUL;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = DIV_WAIT;
        end
      end
      DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          state_nxt     = sts.is_win ? SM_MUL : FINISH;
        end
      end
      SM_MUL: begin
        cmd.sm_mul = 1'b1;
        state_nxt  = SM_ADD;
      end
      SM_ADD: begin
        cmd.sm_add = 1'b1;
        state_nxt  = FINISH;
      end
      FINISH: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_tready  = (state_r == IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// File: hdl/encoder_period_tachometer.sv
// Encoder period tachometer: top level joining controller and datapath.
//
// Input channel (in_*): one beat per event. in_tuser = 0 is an encoder rising
// edge with its microsecond timestamp in in_tdata; in_tuser = 1 closes the
// measurement window. Every input beat yields exactly one output beat.
// Output channel (out_*): instantaneous rpm, window rpm (Q10.8), window valid
// flag and the integer smoothed rpm; out_tuser repeats the input kind.
// Configuration (cfg_*): write min interval, rpm limit, counts per revolution
// and smoothing weight while idle; each write takes effect on the next beat.
// An edge beat is either rejected or has its instantaneous rpm computed by the
// 42-step restoring divider; a window end is empty, saturates when counts per
// revolution is zero, or goes through the divider. One beat is processed at a
// time: no new beat is taken until the current one is through. The result beat
// appears in the same cycle that in_tready returns.
// Reset (rst_n low, synchronous) restores the default configuration and clears
// the edge time, window sums and speed estimates.
// A stalled receiver holds the result in the output register; the next input
// beat is still taken, and its result waits until that register empties.
module encoder_period_tachometer import ept_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] timestamp_us
  input  logic                  in_tuser,   // [0] req_type
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [17:0] instant_rpm_q8, [35:18] window_rpm_q8,
                                            // [36] window_valid, [46:37] smoothed_rpm, [47] 0
  output logic                  out_tuser,  // [0] result_kind
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  ept_cmd_t cmd;
  ept_sts_t sts;

  ept_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ept_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
